FILE: rtl/core/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants for the checksum packet checker: status codes,
// result kinds, configuration register indexes and the result beat layout.
// ----------------------------------------------------------------------------
package cpc_pkg;

    // Bytes of framing overhead: id, length and checksum.
    localparam logic [7:0] OVERHEAD = 8'd3;

    // Register reset values.
    localparam logic [7:0] ID_RESET  = 8'd0;
    localparam logic [7:0] LEN_RESET = 8'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_ID     = 1'b0,
        CFG_EXPECTED_LENGTH = 1'b1
    } t_cfg_idx;

    // Frame status reported in the end-of-frame beat.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ID_ERR   = 2'd1,
        ST_LEN_ERR  = 2'd2,
        ST_CSUM_ERR = 2'd3
    } t_status;

    // Kind of a result beat.
    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    // One result beat.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        t_status    status;
        logic [7:0] payload_count;
    } t_result;

endpackage

FILE: rtl/core/cpc_frame.sv
// ----------------------------------------------------------------------------
// cpc_frame
// Frame tracking state (position, running sum, first error) and the per-byte
// decision of which result, if any, a received byte produces.
// ----------------------------------------------------------------------------
module cpc_frame (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_first,
    input  logic [7:0]       i_expected_id,
    input  logic [7:0]       i_expected_length,
    output logic             o_result_vld,
    output cpc_pkg::t_result o_result
);
    import cpc_pkg::*;

    logic [7:0] r_pos;
    logic [7:0] r_sum;
    t_status    r_err;
    logic       r_active;

    logic [7:0] n_pos;
    logic [7:0] n_sum;
    t_status    n_err;
    logic       n_active;

    logic [7:0] eff_pos;
    logic [7:0] eff_sum;
    t_status    eff_err;
    logic       eff_active;
    logic       len_short;
    logic [7:0] last_pos;
    t_status    end_status;

    // A first flag restarts the frame before the byte is looked at.
    always_comb begin
        eff_pos    = i_first ? 8'd0 : r_pos;
        eff_sum    = i_first ? 8'd0 : r_sum;
        eff_err    = i_first ? ST_OK : r_err;
        eff_active = i_first | r_active;
        len_short  = i_expected_length < OVERHEAD;
        last_pos   = len_short ? (OVERHEAD - 8'd1) : (i_expected_length - 8'd1);
        end_status = eff_err;
        if ((eff_err == ST_OK) && (eff_sum != i_rx_byte)) begin
            end_status = ST_CSUM_ERR;
        end
    end

    // Next state and the result of this byte.
    always_comb begin
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_err        = r_err;
        n_active     = r_active;
        o_result_vld = 1'b0;
        o_result     = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, payload_index: 8'd0,
                         status: ST_OK, payload_count: 8'd0};
        if (i_step && eff_active) begin
            if (eff_pos >= last_pos) begin
                // Checksum byte: close the frame and report.
                n_pos    = 8'd0;
                n_sum    = 8'd0;
                n_err    = ST_OK;
                n_active = 1'b0;
                o_result_vld           = 1'b1;
                o_result.kind          = KIND_STATUS;
                o_result.status        = end_status;
                o_result.payload_count = (end_status == ST_OK) ?
                                         (i_expected_length - OVERHEAD) : 8'd0;
            end else begin
                n_pos    = eff_pos + 8'd1;
                n_sum    = eff_sum + i_rx_byte;
                n_err    = eff_err;
                n_active = 1'b1;
                if (eff_pos == 8'd0) begin
                    if (i_rx_byte != i_expected_id) begin
                        n_err = ST_ID_ERR;
                    end
                end else if (eff_pos == 8'd1) begin
                    if ((eff_err == ST_OK) &&
                        ((i_rx_byte != i_expected_length) || len_short)) begin
                        n_err = ST_LEN_ERR;
                    end
                end else if (eff_err == ST_OK) begin
                    o_result_vld           = 1'b1;
                    o_result.payload_byte  = i_rx_byte;
                    o_result.payload_index = eff_pos - 8'd2;
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_sum    <= 8'd0;
            r_err    <= ST_OK;
            r_active <= 1'b1;
        end else begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_err    <= n_err;
            r_active <= n_active;
        end
    end

endmodule

FILE: rtl/core/checksum_packet_checker.sv
// ----------------------------------------------------------------------------
// checksum_packet_checker
// Streaming checker for frames of id, length, payload and additive checksum.
// ----------------------------------------------------------------------------
// Each input beat carries one frame byte and is taken into an input register;
// when the output register can load, the frame logic updates position, running
// sum and error and loads any result into the output register. One byte is
// accepted per cycle; the only limit on rate is a stalled output register,
// which holds the input register and then the input channel. Payload bytes
// go out with their index while the id and length match; the last byte of a
// frame, placed by expected_length, gives a status beat. Configuration is to
// be written only while idle.
module checksum_packet_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write port.
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // Input channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_first,
    // Output channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_out_kind,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic [1:0] o_status,
    output logic [7:0] o_payload_count
);
    import cpc_pkg::*;

    logic [7:0] r_expected_id;
    logic [7:0] r_expected_length;

    logic       r_s1_vld;
    logic [7:0] r_s1_byte;
    logic       r_s1_first;

    logic       r_out_vld;
    t_result    r_out;

    logic       out_free;
    logic       step;
    logic       res_vld;
    t_result    res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id     <= ID_RESET;
            r_expected_length <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_EXPECTED_ID:     r_expected_id     <= i_cfg_data;
                CFG_EXPECTED_LENGTH: r_expected_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the pipeline moves whenever the output register can load.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign step       = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_byte  <= i_rx_byte;
            r_s1_first <= i_first;
        end
    end

    // Frame tracking and result selection.
    cpc_frame u_frame (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_rx_byte         (r_s1_byte),
        .i_first           (r_s1_first),
        .i_expected_id     (r_expected_id),
        .i_expected_length (r_expected_length),
        .o_result_vld      (res_vld),
        .o_result          (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= step && res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_out_kind      = r_out.kind;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;
    assign o_status        = r_out.status;
    assign o_payload_count = r_out.payload_count;

    // A payload beat never carries a status or a count.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == KIND_PAYLOAD) |->
        (r_out.status == ST_OK && r_out.payload_count == 8'd0))
        else $error("payload beat carries status fields");

    // A failed frame reports no payload count.
    a_error_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == KIND_STATUS && r_out.status != ST_OK) |->
        (r_out.payload_count == 8'd0))
        else $error("error status with non-zero count");

    // A byte held behind a stalled output is not dropped.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && i_out_stall) |=> r_s1_vld)
        else $error("input register lost a byte under stall");

endmodule
